// ----- design/dgf_pkg.sv -----
package dgf_pkg;

  localparam int STATE_FRAC_BITS = 16;

  localparam int CFG_IDX_W = 3;
  localparam int LEN_W     = 11;
  localparam int WORD_W    = 16;
  localparam int UPC_W     = 7;
  localparam int CNT_W     = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LONG = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_VERT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_NORTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_EAST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_DOWN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME   = 3'd5;

  localparam logic [LEN_W-1:0]  RST_LENGTH_LONG = 11'd200;
  localparam logic [LEN_W-1:0]  RST_LENGTH_VERT = 11'd50;
  localparam logic [WORD_W-1:0] RST_SIGMA_NORTH = 16'd8684;
  localparam logic [WORD_W-1:0] RST_SIGMA_EAST  = 16'd8684;
  localparam logic [WORD_W-1:0] RST_SIGMA_DOWN  = 16'd5734;
  localparam logic [WORD_W-1:0] RST_STEP_TIME   = 16'd1311;

  typedef enum logic [4:0] {
    UOP_NOP,
    UOP_DIV_INIT,
    UOP_DIV_STEP,
    UOP_SAVE_Q,
    UOP_SQRT_INIT,
    UOP_SQRT_STEP,
    UOP_ROOT_SAVE,
    UOP_MUL,
    UOP_WB,
    UOP_ACC_NOISE,
    UOP_ACC_SUB,
    UOP_ACC_CLR,
    UOP_ACC_ADDG,
    UOP_DSAVE,
    UOP_SMUL,
    UOP_SWB,
    UOP_GSAVE,
    UOP_END
  } uop_t;

  typedef logic [4:0] sel_t;

  // divider operand / quotient destination
  localparam sel_t DV_LONG = 5'd0;
  localparam sel_t DV_VERT = 5'd1;

  // square root radicand / root destination
  localparam sel_t SQ_2L = 5'd0;
  localparam sel_t SQ_3L = 5'd1;
  localparam sel_t SQ_1L = 5'd2;
  localparam sel_t SQ_3V = 5'd3;
  localparam sel_t SQ_1V = 5'd4;

  // multiplier operand pairs; the first nine also name writeback destinations
  localparam sel_t M_SQ_L = 5'd0;
  localparam sel_t M_SQ_V = 5'd1;
  localparam sel_t M_T_L  = 5'd2;
  localparam sel_t M_T_V  = 5'd3;
  localparam sel_t M_G0   = 5'd4;
  localparam sel_t M_G1   = 5'd5;
  localparam sel_t M_G2   = 5'd6;
  localparam sel_t M_G3   = 5'd7;
  localparam sel_t M_G4   = 5'd8;
  localparam sel_t M_P0X0 = 5'd9;
  localparam sel_t M_P1X1 = 5'd10;
  localparam sel_t M_Q0X2 = 5'd11;
  localparam sel_t M_P2X3 = 5'd12;
  localparam sel_t M_Q1X4 = 5'd13;
  localparam sel_t M_G0X0 = 5'd14;
  localparam sel_t M_G1X1 = 5'd15;
  localparam sel_t M_G2X2 = 5'd16;
  localparam sel_t M_G3X3 = 5'd17;
  localparam sel_t M_G4X4 = 5'd18;

  // axis for noise, derivative and gust
  localparam sel_t AX_N = 5'd0;
  localparam sel_t AX_E = 5'd1;
  localparam sel_t AX_D = 5'd2;

  // filter state index
  localparam sel_t X0 = 5'd0;
  localparam sel_t X1 = 5'd1;
  localparam sel_t X2 = 5'd2;
  localparam sel_t X3 = 5'd3;
  localparam sel_t X4 = 5'd4;

  localparam sel_t END_QUIET = 5'd0;
  localparam sel_t END_EMIT  = 5'd1;

  localparam logic [UPC_W-1:0] AIR_START  = 7'd0;
  localparam logic [UPC_W-1:0] TICK_START = 7'd40;

  typedef struct packed {
    uop_t             op;
    sel_t             sel;
    logic [CNT_W-1:0] last;
  } uinstr_t;

  typedef struct packed {
    uop_t op;
    sel_t sel;
    logic load_in;
    logic load_out;
  } cmd_t;

  function automatic uinstr_t ucode(input logic [UPC_W-1:0] a);
    uinstr_t u;
    unique case (a)
      7'd0:  u = '{UOP_DIV_INIT, DV_LONG, 5'd0};
      7'd1:  u = '{UOP_DIV_STEP, DV_LONG, 5'd23};
      7'd2:  u = '{UOP_SAVE_Q, DV_LONG, 5'd0};
      7'd3:  u = '{UOP_DIV_INIT, DV_VERT, 5'd0};
      7'd4:  u = '{UOP_DIV_STEP, DV_VERT, 5'd23};
      7'd5:  u = '{UOP_SAVE_Q, DV_VERT, 5'd0};
      7'd6:  u = '{UOP_SQRT_INIT, SQ_2L, 5'd0};
      7'd7:  u = '{UOP_SQRT_STEP, SQ_2L, 5'd20};
      7'd8:  u = '{UOP_ROOT_SAVE, SQ_2L, 5'd0};
      7'd9:  u = '{UOP_SQRT_INIT, SQ_3L, 5'd0};
      7'd10: u = '{UOP_SQRT_STEP, SQ_3L, 5'd20};
      7'd11: u = '{UOP_ROOT_SAVE, SQ_3L, 5'd0};
      7'd12: u = '{UOP_SQRT_INIT, SQ_1L, 5'd0};
      7'd13: u = '{UOP_SQRT_STEP, SQ_1L, 5'd20};
      7'd14: u = '{UOP_ROOT_SAVE, SQ_1L, 5'd0};
      7'd15: u = '{UOP_SQRT_INIT, SQ_3V, 5'd0};
      7'd16: u = '{UOP_SQRT_STEP, SQ_3V, 5'd20};
      7'd17: u = '{UOP_ROOT_SAVE, SQ_3V, 5'd0};
      7'd18: u = '{UOP_SQRT_INIT, SQ_1V, 5'd0};
      7'd19: u = '{UOP_SQRT_STEP, SQ_1V, 5'd20};
      7'd20: u = '{UOP_ROOT_SAVE, SQ_1V, 5'd0};
      7'd21: u = '{UOP_MUL, M_SQ_L, 5'd0};
      7'd22: u = '{UOP_WB, M_SQ_L, 5'd0};
      7'd23: u = '{UOP_MUL, M_SQ_V, 5'd0};
      7'd24: u = '{UOP_WB, M_SQ_V, 5'd0};
      7'd25: u = '{UOP_MUL, M_T_L, 5'd0};
      7'd26: u = '{UOP_WB, M_T_L, 5'd0};
      7'd27: u = '{UOP_MUL, M_T_V, 5'd0};
      7'd28: u = '{UOP_WB, M_T_V, 5'd0};
      7'd29: u = '{UOP_MUL, M_G0, 5'd0};
      7'd30: u = '{UOP_WB, M_G0, 5'd0};
      7'd31: u = '{UOP_MUL, M_G1, 5'd0};
      7'd32: u = '{UOP_WB, M_G1, 5'd0};
      7'd33: u = '{UOP_MUL, M_G2, 5'd0};
      7'd34: u = '{UOP_WB, M_G2, 5'd0};
      7'd35: u = '{UOP_MUL, M_G3, 5'd0};
      7'd36: u = '{UOP_WB, M_G3, 5'd0};
      7'd37: u = '{UOP_MUL, M_G4, 5'd0};
      7'd38: u = '{UOP_WB, M_G4, 5'd0};
      7'd39: u = '{UOP_END, END_QUIET, 5'd0};
      7'd40: u = '{UOP_ACC_NOISE, AX_N, 5'd0};
      7'd41: u = '{UOP_MUL, M_P0X0, 5'd0};
      7'd42: u = '{UOP_ACC_SUB, AX_N, 5'd0};
      7'd43: u = '{UOP_DSAVE, AX_N, 5'd0};
      7'd44: u = '{UOP_ACC_NOISE, AX_E, 5'd0};
      7'd45: u = '{UOP_MUL, M_P1X1, 5'd0};
      7'd46: u = '{UOP_ACC_SUB, AX_E, 5'd0};
      7'd47: u = '{UOP_MUL, M_Q0X2, 5'd0};
      7'd48: u = '{UOP_ACC_SUB, AX_E, 5'd0};
      7'd49: u = '{UOP_DSAVE, AX_E, 5'd0};
      7'd50: u = '{UOP_ACC_NOISE, AX_D, 5'd0};
      7'd51: u = '{UOP_MUL, M_P2X3, 5'd0};
      7'd52: u = '{UOP_ACC_SUB, AX_D, 5'd0};
      7'd53: u = '{UOP_MUL, M_Q1X4, 5'd0};
      7'd54: u = '{UOP_ACC_SUB, AX_D, 5'd0};
      7'd55: u = '{UOP_DSAVE, AX_D, 5'd0};
      7'd56: u = '{UOP_SMUL, X0, 5'd0};
      7'd57: u = '{UOP_SWB, X0, 5'd0};
      7'd58: u = '{UOP_SMUL, X2, 5'd0};
      7'd59: u = '{UOP_SWB, X2, 5'd0};
      7'd60: u = '{UOP_SMUL, X1, 5'd0};
      7'd61: u = '{UOP_SWB, X1, 5'd0};
      7'd62: u = '{UOP_SMUL, X4, 5'd0};
      7'd63: u = '{UOP_SWB, X4, 5'd0};
      7'd64: u = '{UOP_SMUL, X3, 5'd0};
      7'd65: u = '{UOP_SWB, X3, 5'd0};
      7'd66: u = '{UOP_ACC_CLR, AX_N, 5'd0};
      7'd67: u = '{UOP_MUL, M_G0X0, 5'd0};
      7'd68: u = '{UOP_ACC_ADDG, AX_N, 5'd0};
      7'd69: u = '{UOP_GSAVE, AX_N, 5'd0};
      7'd70: u = '{UOP_ACC_CLR, AX_E, 5'd0};
      7'd71: u = '{UOP_MUL, M_G1X1, 5'd0};
      7'd72: u = '{UOP_ACC_ADDG, AX_E, 5'd0};
      7'd73: u = '{UOP_MUL, M_G2X2, 5'd0};
      7'd74: u = '{UOP_ACC_ADDG, AX_E, 5'd0};
      7'd75: u = '{UOP_GSAVE, AX_E, 5'd0};
      7'd76: u = '{UOP_ACC_CLR, AX_D, 5'd0};
      7'd77: u = '{UOP_MUL, M_G3X3, 5'd0};
      7'd78: u = '{UOP_ACC_ADDG, AX_D, 5'd0};
      7'd79: u = '{UOP_MUL, M_G4X4, 5'd0};
      7'd80: u = '{UOP_ACC_ADDG, AX_D, 5'd0};
      7'd81: u = '{UOP_GSAVE, AX_D, 5'd0};
      7'd82: u = '{UOP_END, END_EMIT, 5'd0};
      default: u = '{UOP_END, END_QUIET, 5'd0};
    endcase
    return u;
  endfunction

endpackage

// ----- design/dgf_if.sv -----
interface dgf_item_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic        [15:0] airspeed;
  logic signed [15:0] noise_north;
  logic signed [15:0] noise_east;
  logic signed [15:0] noise_down;

  modport source (output valid, kind, airspeed, noise_north, noise_east, noise_down,
                  input ready);
  modport sink (input valid, kind, airspeed, noise_north, noise_east, noise_down,
                output ready);
endinterface

interface dgf_gust_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] gust_north;
  logic signed [15:0] gust_east;
  logic signed [15:0] gust_down;

  modport source (output valid, gust_north, gust_east, gust_down, input ready);
  modport sink (input valid, gust_north, gust_east, gust_down, output ready);
endinterface

interface dgf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/dgf_ctrl.sv -----
module dgf_ctrl (
  input  logic          clk,
  input  logic          rst,
  dgf_item_if.sink      item,
  output logic          out_valid,
  input  logic          out_ready,
  output dgf_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t                          state, state_next;
  logic [dgf_pkg::UPC_W-1:0]       upc, upc_next;
  logic [dgf_pkg::CNT_W-1:0]       cnt, cnt_next;
  logic                            out_valid_next;
  dgf_pkg::uinstr_t                ui;

  assign ui         = dgf_pkg::ucode(upc);
  assign item.ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    upc_next       = upc;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = dgf_pkg::UOP_NOP;
    cmd.sel        = ui.sel;
    cmd.load_in    = 1'b0;
    cmd.load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (item.valid) begin
          cmd.load_in = 1'b1;
          upc_next    = item.kind ? dgf_pkg::TICK_START : dgf_pkg::AIR_START;
          cnt_next    = '0;
          state_next  = S_RUN;
        end
      end
      S_RUN: begin
        if (ui.op == dgf_pkg::UOP_END) begin
          if (ui.sel == dgf_pkg::END_QUIET) begin
            state_next = S_IDLE;
          end else if (!out_valid || out_ready) begin
            cmd.load_out   = 1'b1;
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end else begin
            state_next = S_HOLD;
          end
        end else begin
          cmd.op = ui.op;
          if (cnt == ui.last) begin
            cnt_next = '0;
            upc_next = upc + 1'b1;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      S_HOLD: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      upc       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      upc       <= upc_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- design/dgf_dpath.sv -----
module dgf_dpath #(
  parameter int STATE_FRAC_BITS = dgf_pkg::STATE_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  dgf_item_if.sink           item,
  dgf_cfg_if.sink            cfg,
  input  dgf_pkg::cmd_t      cmd,
  output logic signed [15:0] gust_north,
  output logic signed [15:0] gust_east,
  output logic signed [15:0] gust_down
);

  localparam int UP  = (STATE_FRAC_BITS >= 12) ? STATE_FRAC_BITS - 12 : 0;
  localparam int DN  = (STATE_FRAC_BITS >= 12) ? 0 : 12 - STATE_FRAC_BITS;
  localparam int GSH = STATE_FRAC_BITS + 8;
  localparam logic signed [50:0] DLIM  = 51'sh7FFF_FFFF_FFFF;
  localparam logic signed [50:0] DLIMN = -DLIM;
  localparam logic signed [49:0] XMAX  = 50'sh7FFF_FFFF;
  localparam logic signed [49:0] XMIN  = -50'sh8000_0000;
  localparam logic signed [50:0] GMAX  = 51'sh7FFF;
  localparam logic signed [50:0] GMIN  = -51'sh8000;

  // configuration
  logic [10:0] length_long, length_vert;
  logic [15:0] sigma_north, sigma_east, sigma_down, step_time;

  // latched item
  logic        [15:0] va;
  logic signed [15:0] nz_n, nz_e, nz_d;

  // divider and square root
  logic [23:0] dvd;
  logic [10:0] drem, dvs;
  logic [41:0] rad;
  logic [21:0] srem;
  logic [20:0] root;

  // coefficients
  logic [23:0] rl, rv;
  logic [31:0] sq0, sq1;
  logic [20:0] s2l, s3l, sl, s3v, sv;
  logic [27:0] t2, t4;
  logic [31:0] g0, g1, g2, g3, g4;

  // tick work
  logic signed [31:0] x0, x1, x2, x3, x4;
  logic signed [47:0] d0, d1, dd;
  logic signed [50:0] acc;
  logic signed [65:0] prod;
  logic signed [64:0] sprod;
  logic signed [15:0] w_n, w_e, w_d;

  // combinational
  logic [11:0]        div_sh;
  logic               div_ge;
  logic [11:0]        div_diff;
  logic [23:0]        sq_cur, sq_trial;
  logic               sq_ge;
  logic [23:0]        sq_diff;
  logic [25:0]        rl3, rv3;
  logic [41:0]        rad_sel;
  logic [10:0]        len_sel;
  logic [31:0]        mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic signed [47:0] d_sel;
  logic signed [64:0] smul_p;
  logic signed [31:0] x_sel;
  logic signed [15:0] nz_sel;
  logic signed [50:0] nz_ext, nz_scaled;
  logic signed [65:0] prod_s16, prod_sg;
  logic signed [64:0] sprod_s16;
  logic signed [49:0] x_sum;
  logic signed [31:0] x_new;
  logic signed [47:0] d_sat;
  logic signed [15:0] g_sat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_long <= dgf_pkg::RST_LENGTH_LONG;
      length_vert <= dgf_pkg::RST_LENGTH_VERT;
      sigma_north <= dgf_pkg::RST_SIGMA_NORTH;
      sigma_east  <= dgf_pkg::RST_SIGMA_EAST;
      sigma_down  <= dgf_pkg::RST_SIGMA_DOWN;
      step_time   <= dgf_pkg::RST_STEP_TIME;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        dgf_pkg::CFG_LENGTH_LONG: length_long <= cfg.data[10:0];
        dgf_pkg::CFG_LENGTH_VERT: length_vert <= cfg.data[10:0];
        dgf_pkg::CFG_SIGMA_NORTH: sigma_north <= cfg.data;
        dgf_pkg::CFG_SIGMA_EAST:  sigma_east  <= cfg.data;
        dgf_pkg::CFG_SIGMA_DOWN:  sigma_down  <= cfg.data;
        dgf_pkg::CFG_STEP_TIME:   step_time   <= cfg.data;
        default: ;
      endcase
    end
  end

  // divider step
  assign div_sh   = {drem, dvd[23]};
  assign div_ge   = (div_sh >= {1'b0, dvs});
  assign div_diff = div_sh - {1'b0, dvs};
  assign len_sel  = (cmd.sel == dgf_pkg::DV_VERT) ? length_vert : length_long;

  // square root step
  assign sq_cur   = {srem, rad[41:40]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_ge    = (sq_cur >= sq_trial);
  assign sq_diff  = sq_cur - sq_trial;
  assign rl3      = {2'b00, rl} + {1'b0, rl, 1'b0};
  assign rv3      = {2'b00, rv} + {1'b0, rv, 1'b0};

  always_comb begin
    case (cmd.sel)
      dgf_pkg::SQ_2L: rad_sel = {1'b0, rl, 17'd0};
      dgf_pkg::SQ_3L: rad_sel = {rl3, 16'd0};
      dgf_pkg::SQ_1L: rad_sel = {2'b00, rl, 16'd0};
      dgf_pkg::SQ_3V: rad_sel = {rv3, 16'd0};
      default:        rad_sel = {2'b00, rv, 16'd0};
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.sel)
      dgf_pkg::M_SQ_L: begin mul_a = 32'(rl);          mul_b = 33'(rl);             end
      dgf_pkg::M_SQ_V: begin mul_a = 32'(rv);          mul_b = 33'(rv);             end
      dgf_pkg::M_T_L:  begin mul_a = 32'(rl);          mul_b = 33'(sl);             end
      dgf_pkg::M_T_V:  begin mul_a = 32'(rv);          mul_b = 33'(sv);             end
      dgf_pkg::M_G0:   begin mul_a = 32'(sigma_north); mul_b = 33'(s2l);            end
      dgf_pkg::M_G1:   begin mul_a = 32'(sigma_east);  mul_b = 33'(s3l);            end
      dgf_pkg::M_G2:   begin mul_a = 32'(sigma_east);  mul_b = 33'(t2);             end
      dgf_pkg::M_G3:   begin mul_a = 32'(sigma_down);  mul_b = 33'(s3v);            end
      dgf_pkg::M_G4:   begin mul_a = 32'(sigma_down);  mul_b = 33'(t4);             end
      dgf_pkg::M_P0X0: begin mul_a = 32'(rl);          mul_b = 33'(x0);             end
      dgf_pkg::M_P1X1: begin mul_a = {7'd0, rl, 1'b0}; mul_b = 33'(x1);             end
      dgf_pkg::M_Q0X2: begin mul_a = sq0;              mul_b = 33'(x2);             end
      dgf_pkg::M_P2X3: begin mul_a = {7'd0, rv, 1'b0}; mul_b = 33'(x3);             end
      dgf_pkg::M_Q1X4: begin mul_a = sq1;              mul_b = 33'(x4);             end
      dgf_pkg::M_G0X0: begin mul_a = g0;               mul_b = 33'(x0);             end
      dgf_pkg::M_G1X1: begin mul_a = g1;               mul_b = 33'(x1);             end
      dgf_pkg::M_G2X2: begin mul_a = g2;               mul_b = 33'(x2);             end
      dgf_pkg::M_G3X3: begin mul_a = g3;               mul_b = 33'(x3);             end
      dgf_pkg::M_G4X4: begin mul_a = g4;               mul_b = 33'(x4);             end
      default: ;
    endcase
  end

  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  // step multiplier and state update
  always_comb begin
    case (cmd.sel)
      dgf_pkg::X0: begin d_sel = d0;          x_sel = x0; end
      dgf_pkg::X1: begin d_sel = d1;          x_sel = x1; end
      dgf_pkg::X2: begin d_sel = 48'(x1);     x_sel = x2; end
      dgf_pkg::X3: begin d_sel = dd;          x_sel = x3; end
      default:     begin d_sel = 48'(x3);     x_sel = x4; end
    endcase
  end

  assign smul_p    = $signed({1'b0, step_time}) * d_sel;
  assign sprod_s16 = sprod >>> 16;
  assign x_sum     = 50'(x_sel) + sprod_s16[49:0];
  assign x_new     = (x_sum > XMAX) ? XMAX[31:0] : (x_sum < XMIN) ? XMIN[31:0] : x_sum[31:0];

  // noise rescale and accumulator terms
  always_comb begin
    case (cmd.sel)
      dgf_pkg::AX_N: nz_sel = nz_n;
      dgf_pkg::AX_E: nz_sel = nz_e;
      default:       nz_sel = nz_d;
    endcase
  end

  assign nz_ext    = 51'(nz_sel);
  assign nz_scaled = (nz_ext <<< UP) >>> DN;
  assign prod_s16  = prod >>> 16;
  assign prod_sg   = prod >>> GSH;
  assign d_sat     = (acc > DLIM) ? DLIM[47:0] : (acc < DLIMN) ? DLIMN[47:0] : acc[47:0];
  assign g_sat     = (acc > GMAX) ? GMAX[15:0] : (acc < GMIN) ? GMIN[15:0] : acc[15:0];

  // coefficients and filter states
  always_ff @(posedge clk) begin
    if (rst) begin
      rl  <= '0;
      rv  <= '0;
      sq0 <= '0;
      sq1 <= '0;
      g0  <= '0;
      g1  <= '0;
      g2  <= '0;
      g3  <= '0;
      g4  <= '0;
      x0  <= '0;
      x1  <= '0;
      x2  <= '0;
      x3  <= '0;
      x4  <= '0;
    end else begin
      case (cmd.op)
        dgf_pkg::UOP_SAVE_Q: begin
          if (cmd.sel == dgf_pkg::DV_VERT) begin
            rv <= dvd;
          end else begin
            rl <= dvd;
          end
        end
        dgf_pkg::UOP_WB: begin
          case (cmd.sel)
            dgf_pkg::M_SQ_L: sq0 <= prod[47:16];
            dgf_pkg::M_SQ_V: sq1 <= prod[47:16];
            dgf_pkg::M_G0:   g0  <= prod[43:12];
            dgf_pkg::M_G1:   g1  <= prod[43:12];
            dgf_pkg::M_G2:   g2  <= prod[43:12];
            dgf_pkg::M_G3:   g3  <= prod[43:12];
            dgf_pkg::M_G4:   g4  <= prod[43:12];
            default: ;
          endcase
        end
        dgf_pkg::UOP_SWB: begin
          case (cmd.sel)
            dgf_pkg::X0: x0 <= x_new;
            dgf_pkg::X1: x1 <= x_new;
            dgf_pkg::X2: x2 <= x_new;
            dgf_pkg::X3: x3 <= x_new;
            default:     x4 <= x_new;
          endcase
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      va   <= item.airspeed;
      nz_n <= item.noise_north;
      nz_e <= item.noise_east;
      nz_d <= item.noise_down;
    end
    if (cmd.load_out) begin
      gust_north <= w_n;
      gust_east  <= w_e;
      gust_down  <= w_d;
    end
    case (cmd.op)
      dgf_pkg::UOP_DIV_INIT: begin
        dvd  <= {va, 8'd0};
        drem <= '0;
        dvs  <= (len_sel == '0) ? 11'd1 : len_sel;
      end
      dgf_pkg::UOP_DIV_STEP: begin
        drem <= div_ge ? div_diff[10:0] : div_sh[10:0];
        dvd  <= {dvd[22:0], div_ge};
      end
      dgf_pkg::UOP_SQRT_INIT: begin
        rad  <= rad_sel;
        srem <= '0;
        root <= '0;
      end
      dgf_pkg::UOP_SQRT_STEP: begin
        rad  <= {rad[39:0], 2'b00};
        srem <= sq_ge ? sq_diff[21:0] : sq_cur[21:0];
        root <= {root[19:0], sq_ge};
      end
      dgf_pkg::UOP_ROOT_SAVE: begin
        case (cmd.sel)
          dgf_pkg::SQ_2L: s2l <= root;
          dgf_pkg::SQ_3L: s3l <= root;
          dgf_pkg::SQ_1L: sl  <= root;
          dgf_pkg::SQ_3V: s3v <= root;
          default:        sv  <= root;
        endcase
      end
      dgf_pkg::UOP_MUL: prod <= mul_p;
      dgf_pkg::UOP_WB: begin
        if (cmd.sel == dgf_pkg::M_T_L) begin
          t2 <= prod[43:16];
        end
        if (cmd.sel == dgf_pkg::M_T_V) begin
          t4 <= prod[43:16];
        end
      end
      dgf_pkg::UOP_ACC_NOISE: acc <= nz_scaled;
      dgf_pkg::UOP_ACC_SUB:   acc <= acc - prod_s16[50:0];
      dgf_pkg::UOP_ACC_CLR:   acc <= '0;
      dgf_pkg::UOP_ACC_ADDG:  acc <= acc + prod_sg[50:0];
      dgf_pkg::UOP_DSAVE: begin
        case (cmd.sel)
          dgf_pkg::AX_N: d0 <= d_sat;
          dgf_pkg::AX_E: d1 <= d_sat;
          default:       dd <= d_sat;
        endcase
      end
      dgf_pkg::UOP_SMUL: sprod <= smul_p;
      dgf_pkg::UOP_GSAVE: begin
        case (cmd.sel)
          dgf_pkg::AX_N: w_n <= g_sat;
          dgf_pkg::AX_E: w_e <= g_sat;
          default:       w_d <= g_sat;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ----- design/dryden_gust_filter_top.sv -----
// channel  dir  handshake      word
// item     in   valid/ready    kind, airspeed, noise_north, noise_east, noise_down
// gust     out  valid/ready    gust_north, gust_east, gust_down
// cfg      in   valid/ready    index, data (always ready)
//
// airspeed word: recomputes coefficients, no output (two 24-step divides,
//   five 21-step square roots, nine multiplies on the shared multiplier)
// tick word: run through the microcoded sequence after it is accepted
// one word at a time; item.ready is high only while the sequencer is idle
// a finished gust word sits in the output register while the next word runs;
//   only a second result blocks until the first is taken
// synchronous reset restores configuration defaults and clears coefficients, filter states and sequencer state
module dryden_gust_filter_top #(
  parameter int STATE_FRAC_BITS = dgf_pkg::STATE_FRAC_BITS
) (
  input logic         clk,
  input logic         rst,
  dgf_item_if.sink    item,
  dgf_gust_if.source  gust,
  dgf_cfg_if.sink     cfg
);

  dgf_pkg::cmd_t      cmd;
  logic               out_valid;
  logic signed [15:0] g_n, g_e, g_d;

  dgf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .out_valid (out_valid),
    .out_ready (gust.ready),
    .cmd       (cmd)
  );

  dgf_dpath #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg        (cfg),
    .cmd        (cmd),
    .gust_north (g_n),
    .gust_east  (g_e),
    .gust_down  (g_d)
  );

  assign gust.valid      = out_valid;
  assign gust.gust_north = g_n;
  assign gust.gust_east  = g_e;
  assign gust.gust_down  = g_d;

endmodule
